@@ rtl/point_attractor_physics_step_unit_macros.svh @@
// Assertion macros shared by the point attractor step RTL.
// Each macro expects clk and rst_n in scope.
`ifndef POINT_ATTRACTOR_PHYSICS_STEP_UNIT_MACROS_SVH
`define POINT_ATTRACTOR_PHYSICS_STEP_UNIT_MACROS_SVH

// same-cycle implication
`define PAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pas_pkg.sv @@
// Shared types and constants for the point attractor step block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pas_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DT_BITS       = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int MASS          = 10;
  // 9.8 as 98/10
  localparam int FRIC_NUM      = 98;
  localparam int FRIC_DEN      = 10;
  // shared unit operand width, holds every product and dividend
  localparam int OPW_DEF       = 2 * (WORD_BITS_DEF + FRAC_BITS_DEF + 2);

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRAV,
    CFG_FRIC,
    CFG_ATTR_X,
    CFG_ATTR_Y
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SPD_X,
    S_SPD_Y,
    S_SPD_RT,
    S_DX2,
    S_DY2,
    S_DRT,
    S_ACC_DIV,
    S_AD_MUL,
    S_GX_MUL,
    S_GX_DIV,
    S_GY_MUL,
    S_GY_DIV,
    S_FX2,
    S_FY2,
    S_FRT,
    S_DEC_MUL,
    S_DEC_DIV,
    S_NX_MUL,
    S_NX_DIV,
    S_NY_MUL,
    S_NY_DIV,
    S_PX_MUL,
    S_PY_MUL,
    S_OUT
  } st_t;

endpackage

`default_nettype wire

@@ rtl/pas_alu.sv @@
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
// Depends on pas_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "point_attractor_physics_step_unit_macros.svh"

module pas_alu #(
  parameter int OPW = pas_pkg::OPW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pas_pkg::alu_ctl_t ctl,
  input  logic [OPW-1:0]   opa,
  input  logic [OPW-1:0]   opb,
  output logic             done,
  output logic [OPW-1:0]   res
);
  import pas_pkg::*;

  localparam int CW = $clog2(OPW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  alu_op_t         op_r, op_nxt;
  logic [OPW-1:0]  x_r, x_nxt;
  logic [OPW-1:0]  y_r, y_nxt;
  logic [OPW+1:0]  acc_r, acc_nxt;
  logic [OPW-1:0]  q_r, q_nxt;

  logic [OPW+1:0]  mul_sum;
  logic [OPW+1:0]  div_rem, div_dif;
  logic            div_ge;
  logic [OPW+1:0]  sq_rem, sq_trial, sq_dif;
  logic            sq_ge;

  always_comb begin
    mul_sum  = {acc_r[OPW:0], 1'b0} + {2'b00, (x_r[OPW-1] ? y_r : '0)};
    div_rem  = {acc_r[OPW:0], x_r[OPW-1]};
    div_ge   = div_rem >= {2'b00, y_r};
    div_dif  = div_rem - {2'b00, y_r};
    // two bits of the radicand per step
    sq_rem   = {acc_r[OPW-1:0], x_r[OPW-1 -: 2]};
    sq_trial = {q_r, 2'b01};
    sq_ge    = sq_rem >= sq_trial;
    sq_dif   = sq_rem - sq_trial;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    if (ctl.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      acc_nxt  = '0;
      q_nxt    = '0;
      if (ctl.op == OP_MUL) begin
        x_nxt = opb;
        y_nxt = opa;
      end else begin
        x_nxt = opa;
        y_nxt = opb;
      end
      cnt_nxt = (ctl.op == OP_SQRT) ? CW'(OPW / 2) : CW'(OPW);
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          acc_nxt = mul_sum;
          x_nxt   = x_r << 1;
        end
        OP_DIV: begin
          acc_nxt = div_ge ? div_dif : div_rem;
          q_nxt   = {q_r[OPW-2:0], div_ge};
          x_nxt   = x_r << 1;
        end
        OP_SQRT: begin
          acc_nxt = sq_ge ? sq_dif : sq_rem;
          q_nxt   = {q_r[OPW-2:0], sq_ge};
          x_nxt   = x_r << 2;
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign res  = (op_r == OP_MUL) ? acc_r[OPW-1:0] : q_r;

  `PAS_ASSERT_NOW(a_no_start_busy, ctl.start, !busy_r, "start while unit busy")
  `PAS_ASSERT_NEXT(a_last_gives_done, busy_r && cnt_r == CW'(1), done_r, "done missing")
  `PAS_ASSERT_NOW(a_done_idle, done_r, !busy_r, "done while still busy")

endmodule

`default_nettype wire

@@ rtl/point_attractor_physics_step_unit.sv @@
// Point attractor step unit, a 2D point mass under inverse-square pull,
// friction and Euler integration; one result word per input word. Every
// product, quotient and square root runs on one shared iterative unit of
// OPW = 2*(WORD_BITS+FRAC_BITS+2) bits (100 by default). A load word takes
// 2 multiplies and 1 root; a step word takes up to 20 multiplies/divides and
// 3 roots, fewer when the mass sits on the attractor or the speed is zero.
// Input ready is held low from acceptance until the result word is taken.
// Config writes are always ready.
// Depends on pas_pkg, pas_alu and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "point_attractor_physics_step_unit_macros.svh"

module point_attractor_physics_step_unit #(
  parameter int WORD_BITS = pas_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = pas_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [pas_pkg::DT_BITS-1:0]       in_dt,
  input  logic signed [WORD_BITS-1:0]       in_load_pos_x,
  input  logic signed [WORD_BITS-1:0]       in_load_pos_y,
  input  logic signed [WORD_BITS-1:0]       in_load_vel_x,
  input  logic signed [WORD_BITS-1:0]       in_load_vel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [WORD_BITS-1:0]       out_new_pos_x,
  output logic signed [WORD_BITS-1:0]       out_new_pos_y,
  output logic signed [WORD_BITS-1:0]       out_new_vel_x,
  output logic signed [WORD_BITS-1:0]       out_new_vel_y,
  output logic [WORD_BITS-1:0]              out_speed_before,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pas_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [WORD_BITS-1:0]              cfg_data
);
  import pas_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DT  = DT_BITS;
  localparam int L   = 2 * (WORD_BITS + FRAC_BITS + 2);
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  // sequencer
  st_t       state_r, state_nxt;
  logic      launch_r, launch_nxt;
  alu_ctl_t  alu_ctl;
  alu_op_t   alu_op;
  logic [L-1:0] alu_a, alu_b, alu_res;
  logic      alu_done;

  // configuration and state
  logic [W-1:0]        grav_r, fric_r;
  logic signed [W-1:0] ax_r, ay_r;
  logic signed [W-1:0] px_r, py_r, vx_r, vy_r;

  // latched input word
  logic                func_r;
  logic [DT-1:0]       dt_r;
  logic signed [W-1:0] lpx_r, lpy_r, lvx_r, lvy_r;

  // working values
  logic [L-1:0]        sq_r, work_r;
  logic [W-1:0]        speed_r, a_r, s_r, ns_r;
  logic [W:0]          dist_r;
  logic [W+DT-1:0]     ad_r;

  logic signed [W:0]   dx, dy;
  logic [W:0]          adx, ady;
  logic [W-1:0]        avx, avy;
  logic                dx_pos, dy_pos;
  logic [L-1:0]        sum_sq;
  logic [W+3:0]        g10;
  logic [W+6:0]        fric98;
  logic [L-1:0]        num_l;
  logic [W+3:0]        dec;

  function automatic logic [W-1:0] cap_w(input logic [L-1:0] v);
    cap_w = (|v[L-1:W]) ? '1 : v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] base,
                                                  input logic [W-1:0] m,
                                                  input logic neg);
    logic signed [W+1:0] ext_m;
    logic signed [W+1:0] sum;
    ext_m = $signed({2'b00, m});
    sum   = $signed({{2{base[W-1]}}, base}) + (neg ? -ext_m : ext_m);
    if (sum[W+1:W-1] == 3'b000 || sum[W+1:W-1] == 3'b111) begin
      sat_add = sum[W-1:0];
    end else begin
      sat_add = sum[W+1] ? SMIN : SMAX;
    end
  endfunction

  function automatic logic signed [W-1:0] apply_sign(input logic [W-1:0] m,
                                                     input logic neg);
    apply_sign = neg ? -m : m;
  endfunction

  always_comb begin
    dx     = $signed({px_r[W-1], px_r}) - $signed({ax_r[W-1], ax_r});
    dy     = $signed({py_r[W-1], py_r}) - $signed({ay_r[W-1], ay_r});
    adx    = dx[W] ? -dx : dx;
    ady    = dy[W] ? -dy : dy;
    dx_pos = !dx[W] && (dx != '0);
    dy_pos = !dy[W] && (dy != '0);
    avx    = vx_r[W-1] ? -vx_r : vx_r;
    avy    = vy_r[W-1] ? -vy_r : vy_r;
    sum_sq = sq_r + alu_res;
    g10    = (W+4)'(grav_r) * (W+4)'(MASS);
    fric98 = (W+7)'(fric_r) * (W+7)'(FRIC_NUM);
    num_l  = L'(g10) << (2 * F);
    dec    = alu_res[W+3:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_SPD_X;
      S_SPD_X:   if (alu_done) state_nxt = S_SPD_Y;
      S_SPD_Y:   if (alu_done) state_nxt = S_SPD_RT;
      S_SPD_RT:  if (alu_done) state_nxt = func_r ? S_OUT : S_DX2;
      S_DX2:     if (alu_done) state_nxt = S_DY2;
      // mass on the attractor: skip gravity
      S_DY2:     if (alu_done) state_nxt = (sum_sq == '0) ? S_FX2 : S_DRT;
      S_DRT:     if (alu_done) state_nxt = S_ACC_DIV;
      S_ACC_DIV: if (alu_done) state_nxt = S_AD_MUL;
      S_AD_MUL:  if (alu_done) state_nxt = S_GX_MUL;
      S_GX_MUL:  if (alu_done) state_nxt = S_GX_DIV;
      S_GX_DIV:  if (alu_done) state_nxt = S_GY_MUL;
      S_GY_MUL:  if (alu_done) state_nxt = S_GY_DIV;
      S_GY_DIV:  if (alu_done) state_nxt = S_FX2;
      S_FX2:     if (alu_done) state_nxt = S_FY2;
      S_FY2:     if (alu_done) state_nxt = S_FRT;
      // zero speed: friction does nothing
      S_FRT:     if (alu_done) state_nxt = (alu_res == '0) ? S_PX_MUL : S_DEC_MUL;
      S_DEC_MUL: if (alu_done) state_nxt = S_DEC_DIV;
      S_DEC_DIV: if (alu_done) state_nxt = S_NX_MUL;
      S_NX_MUL:  if (alu_done) state_nxt = S_NX_DIV;
      S_NX_DIV:  if (alu_done) state_nxt = S_NY_MUL;
      S_NY_MUL:  if (alu_done) state_nxt = S_NY_DIV;
      S_NY_DIV:  if (alu_done) state_nxt = S_PX_MUL;
      S_PX_MUL:  if (alu_done) state_nxt = S_PY_MUL;
      S_PY_MUL:  if (alu_done) state_nxt = S_OUT;
      S_OUT:     if (out_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
    launch_nxt = (state_nxt != state_r) && (state_nxt != S_IDLE) && (state_nxt != S_OUT);
  end

  // outputs: operand selection for the shared unit
  always_comb begin
    alu_op = OP_MUL;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      S_SPD_X:   begin alu_a = L'(avx); alu_b = L'(avx); end
      S_SPD_Y:   begin alu_a = L'(avy); alu_b = L'(avy); end
      S_SPD_RT:  begin alu_op = OP_SQRT; alu_a = sq_r; end
      S_DX2:     begin alu_a = L'(adx); alu_b = L'(adx); end
      S_DY2:     begin alu_a = L'(ady); alu_b = L'(ady); end
      S_DRT:     begin alu_op = OP_SQRT; alu_a = sq_r; end
      S_ACC_DIV: begin alu_op = OP_DIV; alu_a = num_l; alu_b = sq_r; end
      S_AD_MUL:  begin alu_a = L'(a_r); alu_b = L'(dt_r); end
      S_GX_MUL:  begin alu_a = L'(ad_r); alu_b = L'(adx); end
      S_GX_DIV:  begin
        alu_op = OP_DIV; alu_a = work_r; alu_b = L'({dist_r, {DT{1'b0}}});
      end
      S_GY_MUL:  begin alu_a = L'(ad_r); alu_b = L'(ady); end
      S_GY_DIV:  begin
        alu_op = OP_DIV; alu_a = work_r; alu_b = L'({dist_r, {DT{1'b0}}});
      end
      S_FX2:     begin alu_a = L'(avx); alu_b = L'(avx); end
      S_FY2:     begin alu_a = L'(avy); alu_b = L'(avy); end
      S_FRT:     begin alu_op = OP_SQRT; alu_a = sq_r; end
      S_DEC_MUL: begin alu_a = L'(fric98); alu_b = L'(dt_r); end
      S_DEC_DIV: begin
        alu_op = OP_DIV; alu_a = work_r; alu_b = L'(FRIC_DEN) << DT;
      end
      S_NX_MUL:  begin alu_a = L'(avx); alu_b = L'(ns_r); end
      S_NX_DIV:  begin alu_op = OP_DIV; alu_a = work_r; alu_b = L'(s_r); end
      S_NY_MUL:  begin alu_a = L'(avy); alu_b = L'(ns_r); end
      S_NY_DIV:  begin alu_op = OP_DIV; alu_a = work_r; alu_b = L'(s_r); end
      S_PX_MUL:  begin alu_a = L'(avx); alu_b = L'(dt_r); end
      S_PY_MUL:  begin alu_a = L'(avy); alu_b = L'(dt_r); end
      default:   begin alu_op = OP_MUL; end
    endcase
    alu_ctl.start = launch_r;
    alu_ctl.op    = alu_op;
  end

  pas_alu #(
    .OPW (L)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .opa   (alu_a),
    .opb   (alu_b),
    .done  (alu_done),
    .res   (alu_res)
  );

  // control, configuration and mass state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      launch_r <= 1'b0;
      grav_r   <= W'(1) << F;
      fric_r   <= '0;
      ax_r     <= '0;
      ay_r     <= -(W'(100) << F);
      px_r     <= '0;
      py_r     <= '0;
      vx_r     <= '0;
      vy_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= launch_nxt;
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GRAV:   grav_r <= cfg_data;
          CFG_FRIC:   fric_r <= cfg_data;
          CFG_ATTR_X: ax_r   <= cfg_data;
          CFG_ATTR_Y: ay_r   <= cfg_data;
          default:    grav_r <= grav_r;
        endcase
      end
      if (alu_done) begin
        case (state_r)
          S_SPD_RT: begin
            if (func_r) begin
              px_r <= lpx_r;
              py_r <= lpy_r;
              vx_r <= lvx_r;
              vy_r <= lvy_r;
            end
          end
          S_GX_DIV: vx_r <= sat_add(vx_r, cap_w(alu_res), dx_pos);
          S_GY_DIV: vy_r <= sat_add(vy_r, cap_w(alu_res), dy_pos);
          S_NX_DIV: vx_r <= apply_sign(alu_res[W-1:0], vx_r[W-1]);
          S_NY_DIV: vy_r <= apply_sign(alu_res[W-1:0], vy_r[W-1]);
          S_PX_MUL: px_r <= sat_add(px_r, alu_res[W+DT-1:DT], vx_r[W-1]);
          S_PY_MUL: py_r <= sat_add(py_r, alu_res[W+DT-1:DT], vy_r[W-1]);
          default:  px_r <= px_r;
        endcase
      end
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      dt_r   <= in_dt;
      lpx_r  <= in_load_pos_x;
      lpy_r  <= in_load_pos_y;
      lvx_r  <= in_load_vel_x;
      lvy_r  <= in_load_vel_y;
    end
    if (alu_done) begin
      case (state_r)
        S_SPD_X, S_DX2, S_FX2: sq_r <= alu_res;
        S_SPD_Y, S_DY2, S_FY2: sq_r <= sum_sq;
        S_SPD_RT:  speed_r <= alu_res[W-1:0];
        S_DRT:     dist_r  <= alu_res[W:0];
        S_ACC_DIV: a_r     <= cap_w(alu_res);
        S_AD_MUL:  ad_r    <= alu_res[W+DT-1:0];
        S_GX_MUL, S_GY_MUL, S_DEC_MUL, S_NX_MUL, S_NY_MUL: work_r <= alu_res;
        S_FRT:     s_r     <= alu_res[W-1:0];
        S_DEC_DIV: ns_r    <= ((W+4)'(s_r) > dec) ? s_r - dec[W-1:0] : '0;
        default:   sq_r    <= sq_r;
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign cfg_ready        = 1'b1;
  assign out_new_pos_x    = px_r;
  assign out_new_pos_y    = py_r;
  assign out_new_vel_x    = vx_r;
  assign out_new_vel_y    = vy_r;
  assign out_speed_before = speed_r;

  `PAS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `PAS_ASSERT_NOW(a_done_in_compute, alu_done, state_r != S_IDLE && state_r != S_OUT,
                  "unit result outside a compute state")
  `PAS_ASSERT_NOW(a_launch_not_done, launch_r, !alu_done, "launch overlaps unit done")

endmodule

`default_nettype wire

@@ tb/sv/point_attractor_physics_step_unit_test.sv @@
// Self-checking bench for point_attractor_physics_step_unit: load and step words,
// predicted in fixed point here and compared field by field with every result word.
// Depends on pas_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module point_attractor_physics_step_unit_test;
  import pas_pkg::*;

  localparam longint WMASK    = 64'hFFFF_FFFF;
  localparam longint SMAX     = 64'sh7FFF_FFFF;
  localparam longint SMIN     = -64'sh8000_0000;
  localparam int     WDOG_MAX = 60000;

  typedef logic [127:0] u128_t;

  typedef struct {
    logic               func;
    logic [15:0]        dt;
    logic signed [31:0] lpx, lpy, lvx, lvy;
    bit                 drain;  // hold the word back until all results are in
  } step_word_t;

  typedef struct {
    logic [31:0] px, py, vx, vy, spd;
  } state_word_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_func = 0;
  logic [DT_BITS-1:0] in_dt = '0;
  logic signed [31:0] in_load_pos_x = '0, in_load_pos_y = '0;
  logic signed [31:0] in_load_vel_x = '0, in_load_vel_y = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_new_pos_x, out_new_pos_y, out_new_vel_x, out_new_vel_y;
  logic [31:0] out_speed_before;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  step_word_t  pending_words[$];
  state_word_t expected_states[$];
  step_word_t  shown_word;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int errors = 0;
  int idle_cycles = 0;

  // predictor copy of the unit
  longint unsigned grav_k, fric_k;
  longint attr_x, attr_y;
  longint mp_x, mp_y, mv_x, mv_y;

  point_attractor_physics_step_unit dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned magn(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic u128_t sq2(longint a, longint b);
    return u128_t'(magn(a)) * u128_t'(magn(a)) + u128_t'(magn(b)) * u128_t'(magn(b));
  endfunction

  function automatic longint unsigned isqrt(u128_t n);
    longint unsigned r, t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (u128_t'(t) * u128_t'(t) <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint clamp_word(longint x);
    return x > SMAX ? SMAX : (x < SMIN ? SMIN : x);
  endfunction

  function automatic longint unsigned cap_word(u128_t x);
    return x > u128_t'(WMASK) ? WMASK : x[63:0];
  endfunction

  function automatic state_word_t advance_point(step_word_t w);
    state_word_t r;
    longint unsigned spd, dist_v, acc, ad, mx, my, s, decel, ns;
    longint dx, dy;
    u128_t d2, den;
    spd = isqrt(sq2(mv_x, mv_y));
    if (w.func) begin
      mp_x = w.lpx; mp_y = w.lpy; mv_x = w.lvx; mv_y = w.lvy;
    end else begin
      dx = mp_x - attr_x;
      dy = mp_y - attr_y;
      d2 = sq2(dx, dy);
      // mass on the attractor: no pull
      if (d2 != 0) begin
        dist_v = isqrt(d2);
        acc  = cap_word((u128_t'(grav_k * MASS) << 32) / d2);
        den  = u128_t'(dist_v) << 16;
        ad   = acc * w.dt;
        mx   = cap_word(u128_t'(ad) * magn(dx) / den);
        my   = cap_word(u128_t'(ad) * magn(dy) / den);
        mv_x = clamp_word(mv_x + (dx > 0 ? -longint'(mx) : longint'(mx)));
        mv_y = clamp_word(mv_y + (dy > 0 ? -longint'(my) : longint'(my)));
      end
      s = isqrt(sq2(mv_x, mv_y));
      if (s > 0) begin
        decel = (u128_t'(fric_k * FRIC_NUM) * w.dt) / (u128_t'(FRIC_DEN) << 16);
        ns = s > decel ? s - decel : 0;
        mx = (u128_t'(magn(mv_x)) * ns) / s;
        my = (u128_t'(magn(mv_y)) * ns) / s;
        mv_x = mv_x < 0 ? -longint'(mx) : longint'(mx);
        mv_y = mv_y < 0 ? -longint'(my) : longint'(my);
      end
      mx = (magn(mv_x) * w.dt) >> 16;
      my = (magn(mv_y) * w.dt) >> 16;
      mp_x = clamp_word(mp_x + (mv_x < 0 ? -longint'(mx) : longint'(mx)));
      mp_y = clamp_word(mp_y + (mv_y < 0 ? -longint'(my) : longint'(my)));
    end
    r.px = mp_x[31:0]; r.py = mp_y[31:0];
    r.vx = mv_x[31:0]; r.vy = mv_y[31:0];
    r.spd = spd[31:0];
    return r;
  endfunction

  task automatic report(string fld, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, fld, got, want);
    errors++;
  endtask

  // sender
  always @(posedge clk) begin : drive_words
    bit took, go;
    took = in_valid && in_ready;
    if (took) expected_states.insert(expected_states.size(), advance_point(shown_word));
    if (!in_valid || in_ready) begin
      go = pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct;
      if (go && pending_words[0].drain && (took || expected_states.size() != 0)) go = 0;
      if (go) begin
        shown_word = pending_words.pop_front();
        in_func       <= shown_word.func;
        in_dt         <= shown_word.dt;
        in_load_pos_x <= shown_word.lpx;
        in_load_pos_y <= shown_word.lpy;
        in_load_vel_x <= shown_word.lvx;
        in_load_vel_y <= shown_word.lvy;
      end
      in_valid <= go;
    end
  end

  // receiver and checker
  always @(posedge clk) begin : check_words
    state_word_t e;
    out_ready <= $urandom_range(99) >= rcv_stall_pct;
    if (out_valid && out_ready) begin
      if (expected_states.size() == 0) begin
        $display("%0t result word with nothing expected", $realtime);
        errors++;
      end else begin
        e = expected_states.pop_front();
        if (out_new_pos_x !== e.px) report("new_pos_x", out_new_pos_x, e.px);
        if (out_new_pos_y !== e.py) report("new_pos_y", out_new_pos_y, e.py);
        if (out_new_vel_x !== e.vx) report("new_vel_x", out_new_vel_x, e.vx);
        if (out_new_vel_y !== e.vy) report("new_vel_y", out_new_vel_y, e.vy);
        if (out_speed_before !== e.spd) report("speed_before", out_speed_before, e.spd);
      end
    end
  end

  // watchdog on handshake silence
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("[point_attractor_physics_step_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_GRAV:   grav_k = val;
      CFG_FRIC:   fric_k = val;
      CFG_ATTR_X: attr_x = longint'(signed'(val));
      default:    attr_y = longint'(signed'(val));
    endcase
  endtask

  task automatic add_word(logic func, logic [15:0] dt, logic [31:0] px, logic [31:0] py,
                          logic [31:0] vx, logic [31:0] vy, bit drain = 0);
    step_word_t w;
    w.func = func; w.dt = dt; w.lpx = px; w.lpy = py; w.lvx = vx; w.lvy = vy;
    w.drain = drain;
    pending_words.insert(pending_words.size(), w);
  endtask

  function automatic logic [31:0] pick_val();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $urandom_range(1, 4) == 1 ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return $urandom_range(0, 16) - 8;
      default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd1092;  // about 1/60 s
      default: return $urandom;
    endcase
  endfunction

  // mostly a load followed by a run of steps; some stray steps and loads
  task automatic add_random(int n);
    int k, steps;
    k = 0;
    while (k < n) begin
      if ($urandom_range(9) < 8) begin
        add_word(1, $urandom, pick_val(), pick_val(), pick_val(), pick_val(),
                 $urandom_range(29) == 0);
        steps = $urandom_range(1, 8);
        repeat (steps) add_word(0, pick_dt(), $urandom, $urandom, $urandom, $urandom);
        k += steps + 1;
      end else begin
        add_word($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom);
        k++;
      end
    end
  endtask

  task automatic drain_all();
    while (pending_words.size() != 0 || in_valid || expected_states.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_phase(int snd, int rcv, int n);
    snd_idle_pct = snd;
    rcv_stall_pct = rcv;
    add_random(n);
    drain_all();
  endtask

  initial begin
    grav_k = 32'h0001_0000;
    fric_k = 0;
    attr_x = 0;
    attr_y = -(64'sd100 << 16);
    mp_x = 0; mp_y = 0; mv_x = 0; mv_y = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // directed: zero state, load extremes, mass on attractor, huge pull
    add_word(0, 16'h0000, '0, '0, '0, '0);
    add_word(0, 16'hFFFF, '0, '0, '0, '0);
    add_word(1, 16'h0000, 32'h0000_0000, 32'hFF9C_0000, 32'h0000_0000, 32'h0000_0000);
    add_word(0, 16'hFFFF, '0, '0, '0, '0);
    add_word(1, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_word(0, 16'hFFFF, '0, '0, '0, '0);
    add_word(1, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    add_word(0, 16'hFFFF, '0, '0, '0, '0);
    add_word(0, 16'h0001, '0, '0, '0, '0);
    add_word(1, 16'h0000, 32'h0000_0001, 32'hFF9C_0000, 32'h0001_0000, 32'hFFFF_0000);
    add_word(0, 16'hFFFF, '0, '0, '0, '0);
    add_word(0, 16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(1, 16'h0000, 32'h0032_0000, 32'h0000_0000, 32'h0000_0000, 32'h0005_0000);
    add_word(0, 16'd1092, '0, '0, '0, '0);
    add_word(0, 16'd1092, '0, '0, '0, '0);
    drain_all();
    run_phase(0, 0, 360);

    write_reg(CFG_GRAV, 32'h0032_0000);
    write_reg(CFG_FRIC, 32'h0000_4000);
    write_reg(CFG_ATTR_X, 32'($signed($urandom_range(0, 100 << 16)) - (50 << 16)));
    write_reg(CFG_ATTR_Y, 32'($signed($urandom_range(0, 100 << 16)) - (50 << 16)));
    add_word(1, 16'h0000, '0, '0, 32'h0002_0000, 32'h0000_0000);
    add_word(0, 16'hFFFF, '0, '0, '0, '0);
    run_phase(53, 0, 320);

    write_reg(CFG_GRAV, 32'hFFFF_FFFF);
    write_reg(CFG_FRIC, 32'hFFFF_FFFF);
    write_reg(CFG_ATTR_X, 32'h8000_0000);
    write_reg(CFG_ATTR_Y, 32'h7FFF_FFFF);
    add_word(1, 16'h0000, 32'h8000_0001, 32'h7FFF_FFFF, 32'h0000_0001, '0);
    add_word(0, 16'hFFFF, '0, '0, '0, '0);
    run_phase(0, 53, 320);

    write_reg(CFG_GRAV, 32'h0000_0000);
    write_reg(CFG_FRIC, 32'h0000_0000);
    write_reg(CFG_ATTR_X, 32'h7FFF_FFFF);
    write_reg(CFG_ATTR_Y, 32'h8000_0000);
    run_phase(8, 8, 320);

    write_reg(CFG_GRAV, $urandom);
    write_reg(CFG_FRIC, $urandom_range(0, 32'h0004_0000));
    write_reg(CFG_ATTR_X, pick_val());
    write_reg(CFG_ATTR_Y, pick_val());
    run_phase(0, 0, 320);

    if (errors == 0) begin
      $display("[point_attractor_physics_step_unit] OK");
    end else begin
      $display("[point_attractor_physics_step_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pas_pkg.sv
rtl/pas_alu.sv
rtl/point_attractor_physics_step_unit.sv
tb/sv/point_attractor_physics_step_unit_test.sv
